// ===== rtl/infix_to_postfix_converter_defines.svh =====
// Assertion macros shared by the converter's checker.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define ITP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itp_checker: same-cycle property violated");

// Next-cycle implication, held off during reset.
`define ITP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itp_checker: next-cycle property violated");

`endif

// ===== rtl/itp_pkg.sv =====
// Shared types, token codes and helpers of the infix to postfix converter.
// No dependencies; imported by every module of the block.
package itp_pkg;

   // Sizes
   localparam int STACK_DEPTH_DEFAULT = 32;
   localparam int VALUE_WIDTH         = 32;
   localparam int DATA_W              = 32;
   localparam int KIND_W              = 4;
   localparam int PREC_W              = 4;
   localparam int NUM_PREC            = 8;
   localparam int REG_IDX_W           = 3;
   localparam int CSR_ADDR_W          = 5;
   localparam int CSR_DATA_W          = 32;
   localparam int RSP_TDATA_W         = ((DATA_W + 1 + 7) / 8) * 8;

   // Operand payload bits kept on output
   localparam logic [DATA_W-1:0] VALUE_MASK =
      (VALUE_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << VALUE_WIDTH) - 64'd1);

   // Token kinds
   localparam logic [KIND_W-1:0] KIND_OPERAND  = 4'd0;
   localparam logic [KIND_W-1:0] KIND_ADD      = 4'd1;
   localparam logic [KIND_W-1:0] KIND_SUBTRACT = 4'd2;
   localparam logic [KIND_W-1:0] KIND_MULTIPLY = 4'd3;
   localparam logic [KIND_W-1:0] KIND_DIVIDE   = 4'd4;
   localparam logic [KIND_W-1:0] KIND_INVERSE  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_NEGATIVE = 4'd6;
   localparam logic [KIND_W-1:0] KIND_LPAREN   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_RPAREN   = 4'd8;
   localparam logic [KIND_W-1:0] KIND_END      = 4'd9;

   // Precedence table, one 4-bit number per operator kind (add first)
   typedef logic [NUM_PREC-1:0][PREC_W-1:0] prec_table_type;

   localparam prec_table_type PREC_RESET = {4'd15, 4'd15, 4'd0, 4'd0,
                                            4'd1, 4'd1, 4'd2, 4'd2};

   // Controller to datapath commands
   typedef struct packed {
      logic latch;        // capture the input beat
      logic push;         // push the held token (dropped when full)
      logic pop;          // pop the stack top and emit it
      logic drop;         // pop a left parenthesis without emitting it
      logic emit_operand; // emit the held operand
      logic emit_end;     // emit the end marker and clear the overflow flag
      logic last;         // the emitted beat is the last one for this item
   } itp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [KIND_W-1:0] kind;  // held token kind
      logic empty;              // stack holds nothing
      logic single;             // stack holds exactly one entry
      logic top_lp;             // top is a left parenthesis
      logic second_lp;          // entry below the top is a left parenthesis
      logic top_yields;         // top binds at least as tightly as the held token
      logic second_yields;      // same for the entry below the top
      logic out_free;           // output register can take a beat this cycle
   } itp_status_type;

   // Precedence number of a kind; zero for kinds without one.
   function automatic logic [PREC_W-1:0] prec_of(input logic [KIND_W-1:0] kind,
                                                 input prec_table_type tbl);
      logic [KIND_W-1:0] idx;
      idx = kind - KIND_ADD;
      if (kind >= KIND_ADD && kind <= KIND_RPAREN) begin
         return tbl[idx[REG_IDX_W-1:0]];
      end
      return '0;
   endfunction

endpackage

// ===== rtl/infix_to_postfix_converter.sv =====
// Shunting-yard infix to postfix converter. A token is taken in one cycle and
// handled from the next; each token popped from the stack gives one output
// beat per cycle while the output register is free, and no new token is
// taken until the last one is done. Results leave from the output register.
// Synchronous active-high reset empties the stack, clears overflow and
// restores default precedences; there is no clearing pass.
module infix_to_postfix_converter import itp_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input tokens
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // [31:0] operand_value
   input  logic [KIND_W-1:0]      req_tuser,   // [3:0] token_kind
   // Postfix tokens
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] out_value, [32] overflow_seen
   output logic [KIND_W-1:0]      rsp_tuser,   // [3:0] out_kind
   output logic                   rsp_tlast,   // last_of_run
   // Configuration
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   prec_table_type    prec_table;
   itp_cmd_type       cmd;
   itp_status_type    status;
   logic [DATA_W-1:0] rsp_value;
   logic              rsp_ovf;

   itp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .prec_table  (prec_table)
   );

   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   itp_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .prec_table (prec_table),
      .req_kind   (req_tuser),
      .req_value  (req_tdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_value  (rsp_value),
      .rsp_ovf    (rsp_ovf),
      .rsp_last   (rsp_tlast)
   );

   // Pack the result beat, padded to whole bytes.
   assign rsp_tdata = RSP_TDATA_W'({rsp_ovf, rsp_value});

endmodule

// ===== rtl/itp_csr.sv =====
// Precedence register file behind the APB-style configuration port.
// Depends on itp_pkg for the table type, reset values and widths.
module itp_csr import itp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output prec_table_type        prec_table
);

   prec_table_type         prec_ff;
   prec_table_type         prec_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   // Word address selects the register.
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_W'(prec_ff[reg_idx]);
   assign prec_table = prec_ff;

   // Write in the access phase.
   always_comb begin
      prec_in = prec_ff;
      if (wr_en) begin
         prec_in[reg_idx] = csr_pwdata[PREC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff <= PREC_RESET;
      end else begin
         prec_ff <= prec_in;
      end
   end

endmodule

// ===== rtl/itp_dpath.sv =====
// Datapath of the converter: held token, operator stack memory, count,
// overflow flag and the output register. Depends on itp_pkg.
module itp_dpath import itp_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  itp_cmd_type       cmd,
   output itp_status_type    status,
   input  prec_table_type    prec_table,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [DATA_W-1:0] rsp_value,
   output logic              rsp_ovf,
   output logic              rsp_last
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   // Held token
   logic [KIND_W-1:0] kind_ff;
   logic [DATA_W-1:0] value_ff;

   // Stack control
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              full;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  top_pos, second_pos;
   logic [ADDR_W-1:0] top_addr, second_addr;

   // Stack memory and its two registered read ports
   logic [KIND_W-1:0] stack_mem [STACK_DEPTH];
   logic [KIND_W-1:0] top_ff, second_ff;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              rsp_last_ff;
   logic              emit;
   logic [PREC_W-1:0] held_prec;

   // Count and overflow flag
   assign full    = (count_ff == CNT_W'(STACK_DEPTH));
   assign wr_en   = cmd.push && !full;
   assign wr_addr = count_ff[ADDR_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop || cmd.drop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      ovf_in = ovf_ff;
      if (cmd.emit_end) begin
         ovf_in = 1'b0;
      end else if (cmd.push && full) begin
         ovf_in = 1'b1;
      end
   end

   // The read ports follow the next count, so the top and the entry below it
   // are ready in the cycle after every push or pop.
   assign top_pos     = count_in - CNT_W'(1);
   assign second_pos  = count_in - CNT_W'(2);
   assign top_addr    = top_pos[ADDR_W-1:0];
   assign second_addr = second_pos[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= kind_ff;
      end
      top_ff    <= (wr_en && wr_addr == top_addr) ? kind_ff : stack_mem[top_addr];
      second_ff <= (wr_en && wr_addr == second_addr) ? kind_ff : stack_mem[second_addr];
   end

   // Output register loads whenever the controller emits.
   assign emit = cmd.pop || cmd.emit_operand || cmd.emit_end;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.pop) begin
         rsp_kind_in = top_ff;
      end else if (cmd.emit_operand) begin
         rsp_kind_in = KIND_OPERAND;
      end else begin
         rsp_kind_in = KIND_END;
      end
      rsp_value_in = cmd.emit_operand ? (value_ff & VALUE_MASK) : '0;
      rsp_ovf_in   = cmd.emit_end && ovf_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
      if (emit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_value_ff <= rsp_value_in;
         rsp_ovf_ff   <= rsp_ovf_in;
         rsp_last_ff  <= cmd.last;
      end
   end

   // Status toward the controller
   assign held_prec = prec_of(kind_ff, prec_table);

   always_comb begin
      status.kind          = kind_ff;
      status.empty         = (count_ff == '0);
      status.single        = (count_ff == CNT_W'(1));
      status.top_lp        = (top_ff == KIND_LPAREN);
      status.second_lp     = (second_ff == KIND_LPAREN);
      status.top_yields    = (prec_of(top_ff, prec_table) <= held_prec);
      status.second_yields = (prec_of(second_ff, prec_table) <= held_prec);
      status.out_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_ovf   = rsp_ovf_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== rtl/itp_ctrl.sv =====
// Controller of the converter: takes one token at a time and steps the
// datapath through pushes, pops and the end flush. Depends on itp_pkg.
module itp_ctrl import itp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  itp_status_type status,
   output itp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_OP_POP   = 3'd2;
   localparam logic [2:0] S_RP_POP   = 3'd3;
   localparam logic [2:0] S_FLUSH    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] step_state;

   assign req_ready = (state_ff == S_IDLE);

   // A freshly held operator, end token or right parenthesis on a non-empty stack
   // starts its loop in the dispatch cycle itself.
   always_comb begin
      step_state = state_ff;
      if (state_ff == S_DISPATCH) begin
         case (status.kind)
            KIND_ADD, KIND_SUBTRACT, KIND_MULTIPLY,
            KIND_DIVIDE, KIND_INVERSE, KIND_NEGATIVE: begin
               step_state = S_OP_POP;
            end
            KIND_RPAREN: begin
               if (!status.empty) begin
                  step_state = S_RP_POP;
               end
            end
            KIND_END: begin
               step_state = S_FLUSH;
            end
            default: begin
               step_state = S_DISPATCH;
            end
         endcase
      end
   end

   // One stack step per cycle; every emitting step waits for the output
   // register to be free.
   always_comb begin
      cmd      = '0;
      state_in = step_state;
      case (step_state)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.kind)
               KIND_OPERAND: begin
                  if (status.out_free) begin
                     cmd.emit_operand = 1'b1;
                     cmd.last         = 1'b1;
                     state_in         = S_IDLE;
                  end
               end
               KIND_LPAREN, KIND_RPAREN: begin
                  // Left parenthesis, or right parenthesis on an empty stack.
                  cmd.push = 1'b1;
                  state_in = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_OP_POP: begin
            if (!status.empty && !status.top_lp && status.top_yields) begin
               if (status.out_free) begin
                  cmd.pop  = 1'b1;
                  cmd.last = status.single || status.second_lp || !status.second_yields;
               end
            end else begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RP_POP: begin
            if (status.empty) begin
               state_in = S_IDLE;
            end else if (status.top_lp) begin
               cmd.drop = 1'b1;
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.pop  = 1'b1;
               cmd.last = status.single || status.second_lp;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               if (!status.empty) begin
                  cmd.pop = 1'b1;
               end else begin
                  cmd.emit_end = 1'b1;
                  cmd.last     = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/itp_checker.sv =====
// Port-level checker for the converter, bound to the top level below.
// Depends on itp_pkg and the assertion macros header.
`include "infix_to_postfix_converter_defines.svh"

module itp_checker import itp_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [KIND_W-1:0]      rsp_tuser,
   input logic                   rsp_tlast
);

   // A stalled result beat holds its contents.
   `ITP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // One token at a time: no input beat right after an accepted one.
   `ITP_ASSERT_NEXT(a_one_token, clock, reset, req_tvalid && req_tready, !req_tready)

   // The end marker always closes its run.
   `ITP_ASSERT_IMPLY(a_end_last, clock, reset, rsp_tvalid && rsp_tuser == KIND_END, rsp_tlast)

   // Overflow is only reported on the end marker.
   `ITP_ASSERT_IMPLY(a_ovf_on_end, clock, reset, rsp_tvalid && rsp_tuser != KIND_END, !rsp_tdata[DATA_W])

   // Only operands carry a payload.
   `ITP_ASSERT_IMPLY(a_value_zero, clock, reset, rsp_tvalid && rsp_tuser != KIND_OPERAND, rsp_tdata[DATA_W-1:0] == '0)

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
